FILE: rtl/core/gat_pkg.sv
// Shared types and constants for the gradient aggregation table.
// Holds verdict codes, controller states, config register indexes and the decision struct.
// No dependencies.
`default_nettype none

package gat_pkg;

  localparam int FragIdxW = 16;
  localparam int RoundW   = 32;
  localparam int IdW      = 8;
  localparam int WordW    = 32;
  localparam int CountW   = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef enum logic [2:0] {
    VERDICT_DROP  = 3'd0,
    VERDICT_PASS  = 3'd1,
    VERDICT_ROOT  = 3'd2,
    VERDICT_RELAY = 3'd3,
    VERDICT_UP    = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_DECIDE = 2'd2,
    ST_WRITE  = 2'd3
  } state_e;

  localparam logic [CfgIdxW-1:0] CFG_OWN_ID            = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PARENT_ID         = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHILDREN_EXPECTED = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HAS_PARENT        = 2'd3;

  typedef struct packed {
    verdict_e verdict;
    logic     accumulate;
    logic     clear;
    logic     rec_we;
  } decision_t;

endpackage

`default_nettype wire

FILE: rtl/core/gradient_aggregation_table_unit.sv
// An item goes from input transfer through a decide state and a write-back state (held
//   while the output stalls) to the output register; the fragment-table and partial-sum
//   memories are read at transfer and written back before the next item is taken.
// Reset: a clearing pass zeroes both memories, with in_stall_o high; config writes are
//   taken during the pass.
// Depends on gat_pkg and gat_decide.
`default_nettype none

module gradient_aggregation_table_unit #(
  parameter int FRAGMENTS = 256,
  parameter int GRADS     = 64,
  parameter int WORKERS   = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [gat_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [gat_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [gat_pkg::FragIdxW-1:0]   frag_index_i,
  input  wire logic [gat_pkg::RoundW-1:0]     round_i,
  input  wire logic [gat_pkg::IdW-1:0]        sender_id_i,
  input  wire logic                           own_broadcast_i,
  input  wire logic [gat_pkg::WordW-1:0]      grad_word_i,
  input  wire logic                           first_word_i,
  input  wire logic                           last_word_i,
  // Output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [2:0]                     verdict_o,
  output logic      [gat_pkg::IdW-1:0]        out_sender_o,
  output logic      [gat_pkg::WordW-1:0]      out_word_o,
  output logic                                out_last_o
);

  localparam int SumDepth = FRAGMENTS * GRADS;
  localparam int FragAw   = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
  localparam int SumAw    = (SumDepth > 1) ? $clog2(SumDepth) : 1;
  localparam int WposW    = $clog2(GRADS + 1);
  localparam int RecW     = gat_pkg::RoundW + gat_pkg::CountW + WORKERS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [gat_pkg::IdW-1:0]    own_id_q;
  logic [gat_pkg::IdW-1:0]    parent_id_q;
  logic [gat_pkg::CountW-1:0] children_expected_q;
  logic                       has_parent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q            <= '0;
      parent_id_q         <= '0;
      children_expected_q <= 8'd1;
      has_parent_q        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gat_pkg::CFG_OWN_ID:            own_id_q            <= cfg_wdata_i;
        gat_pkg::CFG_PARENT_ID:         parent_id_q         <= cfg_wdata_i;
        gat_pkg::CFG_CHILDREN_EXPECTED: children_expected_q <= cfg_wdata_i;
        gat_pkg::CFG_HAS_PARENT:        has_parent_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  gat_pkg::state_e state_q, state_d;
  logic            in_accept;
  logic            res_load;
  logic [SumAw-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gat_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    in_accept = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      gat_pkg::ST_CLEAR: begin
        if (clr_cnt_q == SumAw'(SumDepth - 1)) state_d = gat_pkg::ST_IDLE;
      end
      gat_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_accept = 1'b1;
          state_d   = gat_pkg::ST_DECIDE;
        end
      end
      gat_pkg::ST_DECIDE: begin
        state_d = gat_pkg::ST_WRITE;
      end
      gat_pkg::ST_WRITE: begin
        // Hold the finished item until the output register is free.
        if (!out_valid_o || !out_stall_i) begin
          res_load = 1'b1;
          state_d  = gat_pkg::ST_IDLE;
        end
      end
      default: state_d = gat_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != gat_pkg::ST_IDLE);

  // Sweep every memory entry once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (state_q == gat_pkg::ST_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + SumAw'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Item registers (captured on input transfer)
  // ---------------------------------------------------------------------------
  logic [gat_pkg::FragIdxW-1:0] item_frag_q;
  logic [gat_pkg::RoundW-1:0]   item_round_q;
  logic [gat_pkg::IdW-1:0]      item_sender_q;
  logic                         item_ob_q;
  logic [gat_pkg::WordW-1:0]    item_word_q;
  logic                         item_first_q;
  logic                         item_last_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_frag_q   <= frag_index_i;
      item_round_q  <= round_i;
      item_sender_q <= sender_id_i;
      item_ob_q     <= own_broadcast_i;
      item_word_q   <= grad_word_i;
      item_first_q  <= first_word_i;
      item_last_q   <= last_word_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Packet state
  // ---------------------------------------------------------------------------
  gat_pkg::verdict_e  pkt_verdict_q;
  logic               pkt_acc_q;
  logic               pkt_clr_q;
  logic [FragAw-1:0]  pkt_frag_q;
  logic [WposW-1:0]   word_pos_q;
  gat_pkg::decision_t dec;
  logic               frag_ok;
  logic               in_range;

  assign frag_ok  = {1'b0, item_frag_q} < 17'(FRAGMENTS);
  assign in_range = word_pos_q < WposW'(GRADS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_verdict_q <= gat_pkg::VERDICT_DROP;
      pkt_acc_q     <= 1'b0;
      pkt_clr_q     <= 1'b0;
      pkt_frag_q    <= '0;
      word_pos_q    <= '0;
    end else if (state_q == gat_pkg::ST_DECIDE && item_first_q) begin
      // A first word opens a new packet and abandons any open one.
      pkt_verdict_q <= dec.verdict;
      pkt_acc_q     <= dec.accumulate;
      pkt_clr_q     <= dec.clear;
      pkt_frag_q    <= frag_ok ? item_frag_q[FragAw-1:0] : '0;
      word_pos_q    <= '0;
    end else if (res_load) begin
      if (item_last_q) begin
        pkt_verdict_q <= gat_pkg::VERDICT_DROP;
        pkt_acc_q     <= 1'b0;
        pkt_clr_q     <= 1'b0;
        pkt_frag_q    <= '0;
        word_pos_q    <= '0;
      end else if (in_range) begin
        word_pos_q <= word_pos_q + WposW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fragment table: {round, child count, seen mask} per fragment
  // ---------------------------------------------------------------------------
  logic [RecW-1:0]   frag_mem [FRAGMENTS];
  logic [RecW-1:0]   frag_rdata_q;
  logic              frag_we;
  logic [FragAw-1:0] frag_waddr;
  logic [RecW-1:0]   frag_wdata;
  logic [gat_pkg::RoundW-1:0] new_round;
  logic [gat_pkg::CountW-1:0] new_count;
  logic [WORKERS-1:0]         new_seen;

  always_comb begin
    frag_we    = 1'b0;
    frag_waddr = item_frag_q[FragAw-1:0];
    frag_wdata = {new_round, new_count, new_seen};
    if (state_q == gat_pkg::ST_CLEAR) begin
      frag_we    = {1'b0, clr_cnt_q} < (SumAw + 1)'(FRAGMENTS);
      frag_waddr = clr_cnt_q[FragAw-1:0];
      frag_wdata = '0;
    end else if (state_q == gat_pkg::ST_DECIDE) begin
      frag_we = item_first_q && dec.rec_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frag_we) frag_mem[frag_waddr] <= frag_wdata;
    if (in_accept && first_word_i) frag_rdata_q <= frag_mem[frag_index_i[FragAw-1:0]];
  end

  gat_decide #(
    .WORKERS (WORKERS)
  ) u_decide (
    .frag_ok_i           (frag_ok),
    .own_broadcast_i     (item_ob_q),
    .round_i             (item_round_q),
    .sender_id_i         (item_sender_q),
    .own_id_i            (own_id_q),
    .parent_id_i         (parent_id_q),
    .children_expected_i (children_expected_q),
    .has_parent_i        (has_parent_q),
    .rec_round_i         (frag_rdata_q[RecW-1 -: gat_pkg::RoundW]),
    .rec_count_i         (frag_rdata_q[WORKERS +: gat_pkg::CountW]),
    .rec_seen_i          (frag_rdata_q[WORKERS-1:0]),
    .dec_o               (dec),
    .new_round_o         (new_round),
    .new_count_o         (new_count),
    .new_seen_o          (new_seen)
  );

  // ---------------------------------------------------------------------------
  // Partial-sum memory: one word per fragment and word position
  // ---------------------------------------------------------------------------
  logic [gat_pkg::WordW-1:0] sum_mem [SumDepth];
  logic [gat_pkg::WordW-1:0] sum_rdata_q;
  logic [SumAw-1:0]          sum_raddr;
  logic [SumAw-1:0]          sum_addr_q;
  logic                      sum_re;
  logic                      sum_we;
  logic [SumAw-1:0]          sum_waddr;
  logic [gat_pkg::WordW-1:0] sum_wdata;
  logic [gat_pkg::WordW-1:0] sum_val;
  logic                      sum_touch;
  logic [FragAw-1:0]         raddr_frag;
  logic [WposW-1:0]          raddr_pos;

  // A first word always addresses position zero of its own fragment.
  assign raddr_frag = first_word_i ? frag_index_i[FragAw-1:0] : pkt_frag_q;
  assign raddr_pos  = first_word_i ? '0 : word_pos_q;
  assign sum_raddr  = SumAw'(raddr_frag) * SumAw'(GRADS) + SumAw'(raddr_pos);
  assign sum_re     = in_accept && (first_word_i || in_range);

  always_ff @(posedge clk_i) begin
    if (in_accept) sum_addr_q <= sum_raddr;
  end

  assign sum_touch = in_range && (pkt_acc_q || pkt_clr_q);
  assign sum_val   = !sum_touch ? '0 :
                     pkt_acc_q  ? sum_rdata_q + item_word_q : sum_rdata_q;

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = sum_addr_q;
    sum_wdata = pkt_clr_q ? '0 : sum_val;
    if (state_q == gat_pkg::ST_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_cnt_q;
      sum_wdata = '0;
    end else if (res_load) begin
      sum_we = sum_touch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata_q <= sum_mem[sum_raddr];
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic completion;
  logic send_sum;

  assign completion = (pkt_verdict_q == gat_pkg::VERDICT_ROOT) ||
                      (pkt_verdict_q == gat_pkg::VERDICT_RELAY) ||
                      (pkt_verdict_q == gat_pkg::VERDICT_UP);
  assign send_sum   = (pkt_verdict_q == gat_pkg::VERDICT_ROOT) ||
                      (pkt_verdict_q == gat_pkg::VERDICT_UP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      verdict_o    <= pkt_verdict_q;
      out_sender_o <= completion ? own_id_q : item_sender_q;
      out_word_o   <= send_sum ? sum_val : item_word_q;
      out_last_o   <= item_last_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gat_decide.sv
// Per-packet decision on the first word: verdict, sum control and updated fragment record.
// Depends on gat_pkg.
`default_nettype none

module gat_decide #(
  parameter int WORKERS = 32
) (
  input  wire logic                          frag_ok_i,
  input  wire logic                          own_broadcast_i,
  input  wire logic [gat_pkg::RoundW-1:0]    round_i,
  input  wire logic [gat_pkg::IdW-1:0]       sender_id_i,
  input  wire logic [gat_pkg::IdW-1:0]       own_id_i,
  input  wire logic [gat_pkg::IdW-1:0]       parent_id_i,
  input  wire logic [gat_pkg::CountW-1:0]    children_expected_i,
  input  wire logic                          has_parent_i,
  input  wire logic [gat_pkg::RoundW-1:0]    rec_round_i,
  input  wire logic [gat_pkg::CountW-1:0]    rec_count_i,
  input  wire logic [WORKERS-1:0]            rec_seen_i,
  output gat_pkg::decision_t                 dec_o,
  output logic      [gat_pkg::RoundW-1:0]    new_round_o,
  output logic      [gat_pkg::CountW-1:0]    new_count_o,
  output logic      [WORKERS-1:0]            new_seen_o
);

  logic [WORKERS-1:0]         seen_bit;
  logic [gat_pkg::CountW:0]   limit;

  // Senders at or above WORKERS shift the bit out and skip the duplicate check.
  assign seen_bit = WORKERS'(1) << sender_id_i;
  assign limit    = {1'b0, children_expected_i} + {{gat_pkg::CountW{1'b0}}, 1'b1};

  always_comb begin
    logic [gat_pkg::CountW:0] cnt;
    logic                     dup;
    dec_o       = '{verdict: gat_pkg::VERDICT_DROP, accumulate: 1'b0, clear: 1'b0,
                    rec_we: 1'b0};
    new_round_o = rec_round_i;
    new_count_o = rec_count_i;
    new_seen_o  = rec_seen_i;
    cnt         = {1'b0, rec_count_i};
    dup         = 1'b0;
    if (!frag_ok_i) begin
      dec_o.verdict = gat_pkg::VERDICT_DROP;
    end else if (own_broadcast_i) begin
      dec_o.verdict = gat_pkg::VERDICT_PASS;
    end else if (rec_round_i == round_i) begin
      if (cnt <= {1'b0, children_expected_i}) begin
        if (|(rec_seen_i & seen_bit)) begin
          dup = 1'b1;
        end else begin
          new_seen_o       = rec_seen_i | seen_bit;
          dec_o.accumulate = 1'b1;
          cnt              = cnt + {{gat_pkg::CountW{1'b0}}, 1'b1};
        end
      end
      if (!dup) begin
        dec_o.rec_we = 1'b1;
        new_count_o  = cnt[gat_pkg::CountW-1:0];
        if (cnt >= limit) begin
          if (own_id_i == parent_id_i) begin
            dec_o.verdict = gat_pkg::VERDICT_ROOT;
            dec_o.clear   = 1'b1;
          end else if (sender_id_i == parent_id_i) begin
            dec_o.verdict = gat_pkg::VERDICT_RELAY;
            dec_o.clear   = 1'b1;
          end else if (has_parent_i) begin
            dec_o.verdict = gat_pkg::VERDICT_UP;
          end
          if (dec_o.clear) begin
            // Close the round: reset count and seen mask, advance the round.
            new_count_o = '0;
            new_seen_o  = '0;
            new_round_o = rec_round_i + 32'd1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
